// ===== rtl/ipmd_pkg.sv =====
// Shared types and constants for the incremental PID motor drive.
// Depends on nothing; every other file uses it.
package ipmd_pkg;

  localparam int SPEED_W    = 13;  // measured speed sample, signed
  localparam int SETPOINT_W = 12;
  localparam int GAIN_W     = 10;
  localparam int ILIM_W     = 17;  // integral clamp, signed
  localparam int DRIVE_W    = 16;
  localparam int ERR_W      = 14;  // setpoint minus speed, signed
  localparam int PTERM_W    = 26;  // 15-bit diff times 11-bit gain
  localparam int ITERM_W    = 25;  // 14-bit error times 11-bit gain
  localparam int DTERM_W    = 28;  // 17-bit diff times 11-bit gain
  localparam int SUM_W      = 30;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_SETPOINT = 4'd0,
    REG_GAIN_P         = 4'd1,
    REG_GAIN_I         = 4'd2,
    REG_GAIN_D         = 4'd3,
    REG_INTEGRAL_UPPER = 4'd4,
    REG_INTEGRAL_LOWER = 4'd5,
    REG_DRIVE_UPPER    = 4'd6,
    REG_DRIVE_LOWER    = 4'd7
  } ipmd_reg_t;

  // signed members are kept as plain vectors; users apply $signed
  typedef struct packed {
    logic [SETPOINT_W-1:0] speed_setpoint;
    logic [GAIN_W-1:0]     gain_p;
    logic [GAIN_W-1:0]     gain_i;
    logic [GAIN_W-1:0]     gain_d;
    logic [ILIM_W-1:0]     integral_upper;
    logic [ILIM_W-1:0]     integral_lower;
    logic [DRIVE_W-1:0]    drive_upper;
    logic [DRIVE_W-1:0]    drive_lower;
  } ipmd_cfg_t;

  typedef struct packed {
    logic [PTERM_W-1:0] pterm;
    logic [ILIM_W-1:0]  iterm;
    logic [DTERM_W-1:0] dterm;
  } ipmd_terms_t;

  localparam logic [SETPOINT_W-1:0] RST_SPEED_SETPOINT = 12'd20;
  localparam logic [GAIN_W-1:0]     RST_GAIN_P         = 10'd200;
  localparam logic [GAIN_W-1:0]     RST_GAIN_I         = 10'd0;
  localparam logic [GAIN_W-1:0]     RST_GAIN_D         = 10'd0;
  localparam logic [ILIM_W-1:0]     RST_INTEGRAL_UPPER = 17'd10;
  localparam logic [ILIM_W-1:0]     RST_INTEGRAL_LOWER = 17'h1fff6;  // -10
  localparam logic [DRIVE_W-1:0]    RST_DRIVE_UPPER    = 16'd1000;
  localparam logic [DRIVE_W-1:0]    RST_DRIVE_LOWER    = 16'd0;

endpackage

// ===== rtl/ipmd_ifs.sv =====
// Channel interfaces of the incremental PID motor drive: speed requests,
// drive results and register writes. Depends on ipmd_pkg.
interface ipmd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [ipmd_pkg::SPEED_W-1:0] measured_speed;
  modport source (output valid, output measured_speed, input ready);
  modport sink (input valid, input measured_speed, output ready);
endinterface

interface ipmd_out_if;
  logic                          valid;
  logic                          ready;
  logic [ipmd_pkg::DRIVE_W-1:0]  pwm_duty;
  logic [ipmd_pkg::DRIVE_W-1:0]  drive_level;
  logic                          saturated;
  modport source (output valid, output pwm_duty, output drive_level, output saturated,
                  input ready);
  modport sink (input valid, input pwm_duty, input drive_level, input saturated,
                output ready);
endinterface

interface ipmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ipmd_pkg::CFG_IDX_W-1:0]  index;
  logic [ipmd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ipmd_cfg_regs.sv =====
// Configuration register file of the PID drive.
// Depends on ipmd_pkg.
module ipmd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_valid,
  input  logic [ipmd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [ipmd_pkg::CFG_DATA_W-1:0] wr_data,
  output ipmd_pkg::ipmd_cfg_t             cfg
);
  import ipmd_pkg::*;

  ipmd_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed_setpoint <= RST_SPEED_SETPOINT;
      cfg_r.gain_p         <= RST_GAIN_P;
      cfg_r.gain_i         <= RST_GAIN_I;
      cfg_r.gain_d         <= RST_GAIN_D;
      cfg_r.integral_upper <= RST_INTEGRAL_UPPER;
      cfg_r.integral_lower <= RST_INTEGRAL_LOWER;
      cfg_r.drive_upper    <= RST_DRIVE_UPPER;
      cfg_r.drive_lower    <= RST_DRIVE_LOWER;
    end else if (wr_valid) begin
      unique case (ipmd_reg_t'(wr_index))
        REG_SPEED_SETPOINT: cfg_r.speed_setpoint <= wr_data[SETPOINT_W-1:0];
        REG_GAIN_P:         cfg_r.gain_p         <= wr_data[GAIN_W-1:0];
        REG_GAIN_I:         cfg_r.gain_i         <= wr_data[GAIN_W-1:0];
        REG_GAIN_D:         cfg_r.gain_d         <= wr_data[GAIN_W-1:0];
        REG_INTEGRAL_UPPER: cfg_r.integral_upper <= wr_data[ILIM_W-1:0];
        REG_INTEGRAL_LOWER: cfg_r.integral_lower <= wr_data[ILIM_W-1:0];
        REG_DRIVE_UPPER:    cfg_r.drive_upper    <= wr_data[DRIVE_W-1:0];
        REG_DRIVE_LOWER:    cfg_r.drive_lower    <= wr_data[DRIVE_W-1:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/ipmd_term.sv =====
// Error history and PID increment terms: input register, then the
// three gain products into the term register. Depends on ipmd_pkg.
module ipmd_term (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ipmd_pkg::ipmd_cfg_t                 cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ipmd_pkg::SPEED_W-1:0] in_speed,
  output logic                                term_valid,
  input  logic                                term_ready,
  output ipmd_pkg::ipmd_terms_t               terms
);
  import ipmd_pkg::*;

  logic                      spd_valid_r;
  logic signed [SPEED_W-1:0] spd_r;
  logic                      term_valid_r;
  ipmd_terms_t               terms_r;
  logic signed [ERR_W-1:0]   e1_r;
  logic signed [ERR_W-1:0]   e2_r;

  logic                      load_term;
  logic signed [ERR_W-1:0]   e0;
  logic signed [ERR_W:0]     diff1;
  logic signed [ERR_W+2:0]   diff2;
  logic signed [GAIN_W:0]    gp, gi, gd;
  logic signed [PTERM_W-1:0] pterm;
  logic signed [ITERM_W-1:0] iraw;
  logic signed [DTERM_W-1:0] dterm;
  logic signed [ILIM_W-1:0]  iterm;
  logic signed [ILIM_W-1:0]  ilim_hi, ilim_lo;

  assign load_term = spd_valid_r && (!term_valid_r || term_ready);
  assign in_ready  = !spd_valid_r || load_term;

  always_comb begin
    e0    = $signed({2'b00, cfg.speed_setpoint}) - ERR_W'(spd_r);
    diff1 = (ERR_W+1)'(e0) - (ERR_W+1)'(e1_r);
    diff2 = (ERR_W+3)'(e0) - ((ERR_W+3)'(e1_r) <<< 1) + (ERR_W+3)'(e2_r);
    gp    = $signed({1'b0, cfg.gain_p});
    gi    = $signed({1'b0, cfg.gain_i});
    gd    = $signed({1'b0, cfg.gain_d});
    pterm = PTERM_W'(diff1) * PTERM_W'(gp);
    iraw  = ITERM_W'(e0) * ITERM_W'(gi);
    dterm = DTERM_W'(diff2) * DTERM_W'(gd);
    ilim_hi = $signed(cfg.integral_upper);
    ilim_lo = $signed(cfg.integral_lower);
    // upper limit is tested first, so it wins when the limits cross and the term exceeds it
    if (iraw > ITERM_W'(ilim_hi)) begin
      iterm = ilim_hi;
    end else if (iraw < ITERM_W'(ilim_lo)) begin
      iterm = ilim_lo;
    end else begin
      iterm = iraw[ILIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_valid_r  <= 1'b0;
      term_valid_r <= 1'b0;
      e1_r         <= '0;
      e2_r         <= '0;
    end else begin
      if (in_ready) begin
        spd_valid_r <= in_valid;
      end
      if (load_term) begin
        term_valid_r <= 1'b1;
        e1_r         <= e0;
        e2_r         <= e1_r;
      end else if (term_ready) begin
        term_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      spd_r <= in_speed;
    end
    if (load_term) begin
      terms_r.pterm <= pterm;
      terms_r.iterm <= iterm;
      terms_r.dterm <= dterm;
    end
  end

  assign term_valid = term_valid_r;
  assign terms      = terms_r;

endmodule

// ===== rtl/ipmd_accum.sv =====
// Drive accumulator: adds the PID increment, clamps, forms the PWM duty
// and holds the result register. Depends on ipmd_pkg.
module ipmd_accum #(
  parameter logic [15:0] PWM_TOP = 16'd1000
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ipmd_pkg::ipmd_cfg_t           cfg,
  input  logic                          term_valid,
  output logic                          term_ready,
  input  ipmd_pkg::ipmd_terms_t         terms,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [ipmd_pkg::DRIVE_W-1:0]  pwm_duty,
  output logic [ipmd_pkg::DRIVE_W-1:0]  drive_level,
  output logic                          saturated
);
  import ipmd_pkg::*;

  logic               res_valid_r;
  logic [DRIVE_W-1:0] acc_r;      // stored drive, also the drive_level output
  logic [DRIVE_W-1:0] duty_r;
  logic               sat_r;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] lim_hi, lim_lo;
  logic [DRIVE_W-1:0]      drv;
  logic                    sat;
  logic signed [DRIVE_W:0] duty_raw;
  logic [DRIVE_W-1:0]      duty;

  assign term_ready = !res_valid_r || res_ready;

  always_comb begin
    sum = $signed({{(SUM_W-DRIVE_W){1'b0}}, acc_r})
        + SUM_W'($signed(terms.pterm))
        + SUM_W'($signed(terms.iterm))
        + SUM_W'($signed(terms.dterm));
    lim_hi = $signed({{(SUM_W-DRIVE_W){1'b0}}, cfg.drive_upper});
    lim_lo = $signed({{(SUM_W-DRIVE_W){1'b0}}, cfg.drive_lower});
    if (sum > lim_hi) begin
      drv = cfg.drive_upper;
      sat = 1'b1;
    end else if (sum < lim_lo) begin
      drv = cfg.drive_lower;
      sat = 1'b1;
    end else begin
      drv = sum[DRIVE_W-1:0];
      sat = 1'b0;
    end
    duty_raw = $signed({1'b0, PWM_TOP}) - $signed({1'b0, drv});
    duty     = duty_raw[DRIVE_W] ? '0 : duty_raw[DRIVE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
      acc_r       <= '0;
    end else if (term_ready) begin
      res_valid_r <= term_valid;
      if (term_valid) begin
        acc_r <= drv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (term_ready && term_valid) begin
      duty_r <= duty;
      sat_r  <= sat;
    end
  end

  assign res_valid   = res_valid_r;
  assign pwm_duty    = duty_r;
  assign drive_level = acc_r;
  assign saturated   = sat_r;

endmodule

// ===== rtl/incremental_pid_motor_drive.sv =====
// Incremental (velocity-form) PID speed controller for a PWM motor drive.
// Depends on ipmd_pkg, ipmd_ifs, ipmd_cfg_regs, ipmd_term and ipmd_accum.
//
// Use:
//   in_chan   one request per measured speed sample (13-bit signed).
//   out_chan  one result per request: pwm_duty, drive_level, saturated.
//   cfg_chan  register writes (index, data); always ready. Write only
//             while no request is in flight. Unmapped indexes are dropped.
// Timing:
//   Three register stages (input, gain terms, drive/result): a request is
//   registered in the input stage, then its gain terms, then its drive
//   and result. One request per cycle is sustained while out_ready stays
//   high: the drive accumulator add and clamp closes inside the last
//   stage, and the error history closes inside the term stage.
// Reset:
//   Synchronous, active low. Registers return to their defaults, error
//   history and drive accumulator clear, all stages empty.
// Back pressure:
//   When out_ready is low the result stays put and the pipeline fills;
//   in_ready drops only once all three stages hold a request.
module incremental_pid_motor_drive #(
  parameter logic [15:0] PWM_TOP = 16'd1000
) (
  input  logic        clk,
  input  logic        rst_n,
  ipmd_in_if.sink     in_chan,
  ipmd_out_if.source  out_chan,
  ipmd_cfg_if.sink    cfg_chan
);
  import ipmd_pkg::*;

  ipmd_cfg_t   cfg;
  ipmd_terms_t terms;
  logic        term_valid;
  logic        term_ready;

  // config port never stalls
  assign cfg_chan.ready = 1'b1;

  ipmd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.data),
    .cfg      (cfg)
  );

  // error = setpoint - speed, history shift, Kp/Ki/Kd products, integral clamp
  ipmd_term u_term (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_speed   (in_chan.measured_speed),
    .term_valid (term_valid),
    .term_ready (term_ready),
    .terms      (terms)
  );

  // drive += increment, clamp, duty = PWM_TOP - drive (floor at zero)
  ipmd_accum #(
    .PWM_TOP (PWM_TOP)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .term_valid  (term_valid),
    .term_ready  (term_ready),
    .terms       (terms),
    .res_valid   (out_chan.valid),
    .res_ready   (out_chan.ready),
    .pwm_duty    (out_chan.pwm_duty),
    .drive_level (out_chan.drive_level),
    .saturated   (out_chan.saturated)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for incremental_pid_motor_drive: a directed table of speed
// samples and register writes, then randomized control phases checked by a local model.
// Depends on ipmd_pkg, the channel interfaces in ipmd_ifs and the RTL top level.
`timescale 1ns / 1ps

module testbench;
  import ipmd_pkg::*;

  localparam int PWM_TOP         = 1000;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 86;
  localparam int PRESSURE_PHASE  = 4;     // phase that opens with a long output hold-off
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 2000;  // quiet cycles, far above any legal stall
  localparam int TAIL_CYCLES     = 8;     // idle margin after the last result
  localparam int MAX_REPORTS     = 20;
  localparam int DIR_ROWS        = 48;

  // indexes with no register behind them; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 4'd15;

  typedef enum logic [0:0] {ROW_SAMPLE, ROW_WRITE} row_kind_t;
  typedef enum int {CFG_MAXED, CFG_MINNED, CFG_RANDOM} cfg_style_t;

  typedef struct packed {
    logic [DRIVE_W-1:0] pwm_duty;
    logic [DRIVE_W-1:0] drive_level;
    logic               saturated;
  } drive_result_t;

  // travels with each speed request; a pinned request carries its hand-worked result
  typedef struct packed {
    logic          pinned;
    drive_result_t res;
  } sample_tag_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_IDX_W-1:0]       index;
    logic [CFG_DATA_W-1:0]      data;
    logic signed [SPEED_W-1:0]  speed;
    logic                       pinned;
    drive_result_t              res;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ipmd_in_if  speed_req ();
  ipmd_out_if drive_rsp ();
  ipmd_cfg_if reg_wr ();

  incremental_pid_motor_drive #(
    .PWM_TOP(16'(PWM_TOP))
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (speed_req),
    .out_chan(drive_rsp),
    .cfg_chan(reg_wr)
  );

  // ---------------------------------------------------------------------------
  // Local copy of the controller: registers, error history, drive accumulator
  // ---------------------------------------------------------------------------
  logic [SETPOINT_W-1:0]     setpoint_m;
  logic [GAIN_W-1:0]         gain_p_m;
  logic [GAIN_W-1:0]         gain_i_m;
  logic [GAIN_W-1:0]         gain_d_m;
  logic signed [ILIM_W-1:0]  int_upper_m;
  logic signed [ILIM_W-1:0]  int_lower_m;
  logic [DRIVE_W-1:0]        drive_upper_m;
  logic [DRIVE_W-1:0]        drive_lower_m;
  logic signed [ERR_W-1:0]   err_prev;
  logic signed [ERR_W-1:0]   err_prev2;
  logic [DRIVE_W-1:0]        drive_acc_m;

  drive_result_t drive_expect_q [$];
  sample_tag_t   sample_tag_q [$];

  // set by the main sequence; the result sink also uses out_stall_style and hold_off_req
  int in_gap_style;
  int out_stall_style;
  bit hold_off_req;

  int errors;
  int reports;
  int requests_seen;
  int results_seen;
  int writes_seen;
  int saturated_seen;
  int zero_duty_seen;
  int hold_offs_done;
  int quiet_cycles;

  function automatic void load_defaults();
    setpoint_m    = RST_SPEED_SETPOINT;
    gain_p_m      = RST_GAIN_P;
    gain_i_m      = RST_GAIN_I;
    gain_d_m      = RST_GAIN_D;
    int_upper_m   = RST_INTEGRAL_UPPER;
    int_lower_m   = RST_INTEGRAL_LOWER;
    drive_upper_m = RST_DRIVE_UPPER;
    drive_lower_m = RST_DRIVE_LOWER;
    err_prev      = '0;
    err_prev2     = '0;
    drive_acc_m   = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_SPEED_SETPOINT: setpoint_m    = value[SETPOINT_W-1:0];
      REG_GAIN_P:         gain_p_m      = value[GAIN_W-1:0];
      REG_GAIN_I:         gain_i_m      = value[GAIN_W-1:0];
      REG_GAIN_D:         gain_d_m      = value[GAIN_W-1:0];
      REG_INTEGRAL_UPPER: int_upper_m   = value;
      REG_INTEGRAL_LOWER: int_lower_m   = value;
      REG_DRIVE_UPPER:    drive_upper_m = value[DRIVE_W-1:0];
      REG_DRIVE_LOWER:    drive_lower_m = value[DRIVE_W-1:0];
      default: ;  // unmapped index: dropped
    endcase
  endfunction

  // One control step. All terms are formed exactly in 64 bits; the upper
  // limit is tested before the lower one for both clamps, so crossed limits
  // resolve to the upper value whenever the term exceeds it.
  function automatic drive_result_t predict_drive(input logic signed [SPEED_W-1:0] speed);
    longint e0, e1, e2, pterm, iterm, dterm, sum, drv, duty;
    drive_result_t r;
    r.saturated = 1'b0;
    e0 = longint'(setpoint_m) - longint'(speed);
    e1 = longint'(err_prev);
    e2 = longint'(err_prev2);
    pterm = longint'(gain_p_m) * (e0 - e1);
    dterm = longint'(gain_d_m) * (e0 - 2 * e1 + e2);
    iterm = longint'(gain_i_m) * e0;
    if (iterm > longint'(int_upper_m))
      iterm = longint'(int_upper_m);
    else if (iterm < longint'(int_lower_m))
      iterm = longint'(int_lower_m);
    sum = longint'(drive_acc_m) + pterm + iterm + dterm;
    if (sum > longint'(drive_upper_m)) begin
      drv = longint'(drive_upper_m);
      r.saturated = 1'b1;
    end else if (sum < longint'(drive_lower_m)) begin
      drv = longint'(drive_lower_m);
      r.saturated = 1'b1;
    end else begin
      drv = sum;
    end
    err_prev2   = err_prev;
    err_prev    = ERR_W'(e0);
    drive_acc_m = DRIVE_W'(drv);
    // duty floors at zero once the drive passes the PWM period
    duty = longint'(PWM_TOP) - longint'(drive_acc_m);
    if (duty < 0) duty = 0;
    r.pwm_duty    = DRIVE_W'(duty);
    r.drive_level = drive_acc_m;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic stim_row_t sample_row(input logic signed [SPEED_W-1:0] speed);
    stim_row_t row;
    row = '0;
    row.kind  = ROW_SAMPLE;
    row.speed = speed;
    return row;
  endfunction

  function automatic stim_row_t pinned_row(input logic signed [SPEED_W-1:0] speed,
                                           input int duty, input int drive, input bit sat);
    stim_row_t row;
    row = sample_row(speed);
    row.pinned              = 1'b1;
    row.res.pwm_duty        = DRIVE_W'(duty);
    row.res.drive_level     = DRIVE_W'(drive);
    row.res.saturated       = sat;
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx, input int value);
    stim_row_t row;
    row = '0;
    row.kind  = ROW_WRITE;
    row.index = idx;
    row.data  = CFG_DATA_W'(value);
    return row;
  endfunction

  // idle cycles before one request or one result: none, a uniform random draw, or rare bursts
  function automatic int draw_wait(input int style);
    if (style == 0) return 0;
    if (style == 1) return int'($urandom_range(0, 16));
    return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 16)) : 0;
  endfunction

  // register value with random bits above its width, which the block must mask
  function automatic logic [CFG_DATA_W-1:0] noisy(input int value, input int w);
    int m;
    m = (1 << w) - 1;
    return CFG_DATA_W'((value & m) | (int'($urandom) & ~m));
  endfunction

  function automatic int pick_gain();
    case ($urandom_range(0, 3))
      0, 1:    return int'($urandom_range(0, 15));
      2:       return int'($urandom_range(0, 127));
      default: return int'($urandom_range(0, 1023));
    endcase
  endfunction

  // mostly near the setpoint so the loop stays out of saturation, plus noise and extremes
  function automatic logic signed [SPEED_W-1:0] rand_speed(input int target);
    int pick;
    int near;
    pick = int'($urandom_range(0, 19));
    near = target + int'($urandom_range(0, 128)) - 64;
    if (pick < 14) return SPEED_W'(near);
    if (pick < 17) return SPEED_W'($urandom);
    if (pick == 17) return {1'b1, {(SPEED_W-1){1'b0}}};
    if (pick == 18) return {1'b0, {(SPEED_W-1){1'b1}}};
    return '0;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    reg_wr.valid <= 1'b1;
    reg_wr.index <= idx;
    reg_wr.data  <= value;
    do @(posedge clk); while (!reg_wr.ready);
  endtask

  // valid is left high after acceptance so back-to-back requests never drop it
  task automatic send_sample(input logic signed [SPEED_W-1:0] speed, input logic pinned,
                             input drive_result_t res);
    int gap;
    sample_tag_t tag;
    gap = draw_wait(in_gap_style);
    if (gap > 0) begin
      speed_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tag.pinned = pinned;
    tag.res    = res;
    sample_tag_q.push_back(tag);
    speed_req.valid          <= 1'b1;
    speed_req.measured_speed <= speed;
    do @(posedge clk); while (!speed_req.ready);
  endtask

  // waits on a clock edge before testing, so the request accepted at this edge is already queued
  task automatic wait_quiet();
    do @(posedge clk); while (drive_expect_q.size() != 0);
  endtask

  // writes every register for one phase; returns the setpoint the samples aim at
  task automatic program_phase(input cfg_style_t style, output int target);
    int sp, gp, gi, gd, iu, il, du, dl;
    case (style)
      CFG_MAXED: begin
        sp = 4095; gp = 1023; gi = 1023; gd = 1023;
        iu = 65535; il = -65536; du = 65535; dl = 0;
      end
      CFG_MINNED: begin
        sp = 0; gp = 0; gi = 0; gd = 0;
        iu = -65536; il = -65536; du = 0; dl = 0;
      end
      default: begin
        sp = int'($urandom_range(0, 4095));
        gp = pick_gain();
        gi = pick_gain();
        gd = pick_gain();
        iu = ($urandom_range(0, 4) != 0) ? int'($urandom_range(0, 3000)) : int'($urandom);
        il = ($urandom_range(0, 4) != 0) ? -int'($urandom_range(0, 3000)) : int'($urandom);
        du = ($urandom_range(0, 1) != 0) ? int'($urandom_range(PWM_TOP / 2, PWM_TOP))
                                         : int'($urandom_range(0, 65535));
        dl = ($urandom_range(0, 4) != 0) ? int'($urandom_range(0, du / 4))
                                         : int'($urandom_range(0, 65535));
      end
    endcase
    write_reg(REG_SPEED_SETPOINT, noisy(sp, SETPOINT_W));
    write_reg(REG_GAIN_P,         noisy(gp, GAIN_W));
    write_reg(REG_GAIN_I,         noisy(gi, GAIN_W));
    write_reg(REG_GAIN_D,         noisy(gd, GAIN_W));
    write_reg(REG_INTEGRAL_UPPER, noisy(iu, ILIM_W));
    write_reg(REG_INTEGRAL_LOWER, noisy(il, ILIM_W));
    write_reg(REG_DRIVE_UPPER,    noisy(du, DRIVE_W));
    write_reg(REG_DRIVE_LOWER,    noisy(dl, DRIVE_W));
    target = sp;
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Request tracking: register writes update the local copy, each accepted
  // speed request advances it and queues the result it must produce.
  // Writes only happen while idle, so their order against requests is moot.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    drive_result_t predicted;
    sample_tag_t tag;
    if (rst_n) begin
      if (reg_wr.valid && reg_wr.ready) begin
        apply_reg(reg_wr.index, reg_wr.data);
        writes_seen++;
      end
      if (speed_req.valid && speed_req.ready) begin
        predicted = predict_drive(speed_req.measured_speed);
        tag = sample_tag_q.pop_front();
        // a pinned row is checked against its hand-worked value instead
        drive_expect_q.push_back(tag.pinned ? tag.res : predicted);
        requests_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    drive_result_t want;
    drive_result_t got;
    if (rst_n && drive_rsp.valid && drive_rsp.ready) begin
      got.pwm_duty    = drive_rsp.pwm_duty;
      got.drive_level = drive_rsp.drive_level;
      got.saturated   = drive_rsp.saturated;
      results_seen++;
      if (got.saturated) saturated_seen++;
      if (got.pwm_duty == '0) zero_duty_seen++;
      if (drive_expect_q.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t ERROR result with no request pending: duty=%0d drive=%0d sat=%0d",
                   $time, got.pwm_duty, got.drive_level, got.saturated);
        end
      end else begin
        want = drive_expect_q.pop_front();
        if (got !== want) begin
          errors++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t ERROR result mismatch: expected duty=%0d drive=%0d sat=%0d,",
                     $time, want.pwm_duty, want.drive_level, want.saturated,
                     " got duty=%0d drive=%0d sat=%0d",
                     got.pwm_duty, got.drive_level, got.saturated);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no handshake on any channel for too long ends the run
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((speed_req.valid && speed_req.ready) || (drive_rsp.valid && drive_rsp.ready) ||
          (reg_wr.valid && reg_wr.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ERROR watchdog: no handshake for %0d cycles, %0d results pending",
                 $time, quiet_cycles, drive_expect_q.size());
        $display("FAIL incremental_pid_motor_drive");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stalls per result, and one long hold-off on request
  // so the pipeline fills and in_ready has to drop
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    drive_rsp.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        drive_rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        hold_offs_done++;
      end else begin
        n = draw_wait(out_stall_style);
        if (n > 0) begin
          drive_rsp.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      drive_rsp.ready <= 1'b1;
      do @(posedge clk); while (!drive_rsp.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    stim_row_t script [DIR_ROWS];
    row_kind_t last_kind;
    int target;
    cfg_style_t style;

    errors = 0;
    reports = 0;
    requests_seen = 0;
    results_seen = 0;
    writes_seen = 0;
    saturated_seen = 0;
    zero_duty_seen = 0;
    hold_offs_done = 0;
    quiet_cycles = 0;
    hold_off_req = 1'b0;
    in_gap_style = 1;
    out_stall_style = 1;
    load_defaults();

    rst_n                    <= 1'b0;
    speed_req.valid          <= 1'b0;
    speed_req.measured_speed <= '0;
    reg_wr.valid             <= 1'b0;
    reg_wr.index             <= '0;
    reg_wr.data              <= '0;

    // Directed rows. The first five run from reset values (setpoint 20, Kp 200,
    // drive limits 0..1000), so their results follow from Kp times the error step.
    script = '{
      pinned_row(20, 1000, 0, 1'b0),       // zero error, nothing moves
      pinned_row(21, 1000, 0, 1'b1),       // -200 step, clamped at the lower limit
      pinned_row(16, 0, 1000, 1'b0),       // lands exactly on the upper limit
      pinned_row(-4096, 0, 1000, 1'b1),    // most negative speed
      pinned_row(4095, 1000, 0, 1'b1),     // most positive speed
      // setpoint, gains and upper limits at their top, widest integral window
      write_row(REG_SPEED_SETPOINT, 4095),
      write_row(REG_GAIN_P, 1023),
      write_row(REG_GAIN_I, 1023),
      write_row(REG_GAIN_D, 1023),
      write_row(REG_INTEGRAL_UPPER, 65535),
      write_row(REG_INTEGRAL_LOWER, -65536),
      write_row(REG_DRIVE_UPPER, 65535),
      write_row(REG_DRIVE_LOWER, 0),
      pinned_row(-4096, 0, 65535, 1'b1),   // largest error; drive past PWM_TOP, duty 0
      pinned_row(4095, 1000, 0, 1'b1),     // huge negative step
      sample_row(4000),
      sample_row(4090),
      // setpoint, gains, drive limits at 0; crossed integral window forces upper value
      write_row(REG_SPEED_SETPOINT, 0),
      write_row(REG_GAIN_P, 0),
      write_row(REG_GAIN_I, 0),
      write_row(REG_GAIN_D, 0),
      write_row(REG_INTEGRAL_UPPER, -65536),
      write_row(REG_INTEGRAL_LOWER, 65535),
      write_row(REG_DRIVE_UPPER, 0),
      write_row(REG_DRIVE_LOWER, 0),
      pinned_row(0, 1000, 0, 1'b1),
      pinned_row(0, 1000, 0, 1'b1),
      // crossed drive limits: sum 0 sits below 500 -> 500, then 500 is above 100 -> 100
      write_row(REG_INTEGRAL_UPPER, 0),
      write_row(REG_INTEGRAL_LOWER, 0),
      write_row(REG_DRIVE_UPPER, 100),
      write_row(REG_DRIVE_LOWER, 500),
      pinned_row(0, 500, 500, 1'b1),
      pinned_row(0, 900, 100, 1'b1),
      // unmapped indexes must leave every register alone
      write_row(REG_UNMAPPED_LO, 'h1ffff),
      write_row(REG_UNMAPPED_HI, 'h1ffff),
      pinned_row(0, 500, 500, 1'b1),
      // a mild loop with all three terms active
      write_row(REG_SPEED_SETPOINT, 20),
      write_row(REG_GAIN_P, 200),
      write_row(REG_GAIN_I, 5),
      write_row(REG_GAIN_D, 3),
      write_row(REG_INTEGRAL_UPPER, 10),
      write_row(REG_INTEGRAL_LOWER, -10),
      write_row(REG_DRIVE_UPPER, 1000),
      write_row(REG_DRIVE_LOWER, 0),
      sample_row(25),
      sample_row(18),
      sample_row(30),
      sample_row(12)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the table; a run of writes starts only once the block has drained
    last_kind = ROW_SAMPLE;
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (script[i].kind == ROW_WRITE) begin
        if (last_kind == ROW_SAMPLE) begin
          speed_req.valid <= 1'b0;
          wait_quiet();
        end
        write_reg(script[i].index, script[i].data);
      end else begin
        if (last_kind == ROW_WRITE) reg_wr.valid <= 1'b0;
        send_sample(script[i].speed, script[i].pinned, script[i].res);
      end
      last_kind = script[i].kind;
    end

    // random phases: fresh registers each time, the first two at the extremes
    for (int p = 0; p < PHASES; p++) begin
      speed_req.valid <= 1'b0;
      wait_quiet();
      style = (p == 0) ? CFG_MAXED : (p == 1) ? CFG_MINNED : CFG_RANDOM;
      program_phase(style, target);
      reg_wr.valid <= 1'b0;
      in_gap_style    = int'($urandom_range(0, 2));
      out_stall_style = int'($urandom_range(0, 2));
      if (p == PRESSURE_PHASE) begin
        // sender keeps pushing while the sink holds off after its first result
        hold_off_req = 1'b1;
        in_gap_style = 0;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++)
        send_sample(rand_speed(target), 1'b0, '0);
    end

    speed_req.valid <= 1'b0;
    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d speed requests and %0d results",
             requests_seen, results_seen,
             " (%0d saturated, %0d at zero duty)", saturated_seen, zero_duty_seen);
    $display("over %0d register writes, %0d random phases",
             writes_seen, PHASES,
             " and %0d long output hold-off(s); %0d errors", hold_offs_done, errors);
    if (errors == 0)
      $display("PASS incremental_pid_motor_drive");
    else
      $display("FAIL incremental_pid_motor_drive");
    $finish;
  end

endmodule
